// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("checker assertion failed");

// Check a property on every rising clock edge, reset included.
`define CHK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("checker assertion failed");

`endif

// ----- rtl/mexp_pkg.sv -----
// Package for the 64-bit modular exponentiation block.
// Holds word widths, the cell control bundle and the modular add helper.
package mexp_pkg;

    localparam int WORD_W = 64;
    localparam int CNT_W  = 6;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Control bundle from the sequencer to each multiplier cell
    typedef struct packed {
        logic start;
        logic step;
    } t_cell_ctl;

    // (x + y) mod m with the wrap taken through the gap m - y
    function automatic t_word add_mod(input t_word x, input t_word y, input t_word m);
        t_word gap;
        gap = m - y;
        if (x >= gap) begin
            return x - gap;
        end
        return x + y;
    endfunction

endpackage

// ----- rtl/mexp_if.sv -----
// Channel interfaces for the modular exponentiation block.
// Depends on mexp_pkg for the word type.
interface mexp_in_if;
    logic             valid;
    logic             ready;
    mexp_pkg::t_word  base_value;
    mexp_pkg::t_word  exponent;
    mexp_pkg::t_word  modulus;
    modport source (output valid, output base_value, output exponent, output modulus,
                    input ready);
    modport sink   (input valid, input base_value, input exponent, input modulus,
                    output ready);
endinterface

interface mexp_out_if;
    logic             valid;
    logic             ready;
    mexp_pkg::t_word  power_result;
    logic             zero_modulus_error;
    modport source (output valid, output power_result, output zero_modulus_error,
                    input ready);
    modport sink   (input valid, input power_result, input zero_modulus_error,
                    output ready);
endinterface

// ----- rtl/mexp_cell.sv -----
// Bit-serial interleaved modular multiplier cell: acc = a * b mod m.
// Depends on mexp_pkg (add_mod, t_cell_ctl); one multiplier bit per step.
module mexp_cell (
    input  logic                i_clk,
    input  mexp_pkg::t_cell_ctl i_ctl,
    input  mexp_pkg::t_word     i_a,
    input  mexp_pkg::t_word     i_b,
    input  mexp_pkg::t_word     i_m,
    output mexp_pkg::t_word     o_acc
);
    import mexp_pkg::*;

    t_word r_acc, n_acc;
    t_word r_b, n_b;
    t_word w_dbl;

    // Double, then add a when the top multiplier bit is set
    always_comb begin
        w_dbl = add_mod(r_acc, r_acc, i_m);
        n_acc = r_acc;
        n_b   = r_b;
        if (i_ctl.start) begin
            n_acc = '0;
            n_b   = i_b;
        end else if (i_ctl.step) begin
            n_acc = r_b[WORD_W-1] ? add_mod(w_dbl, i_a, i_m) : w_dbl;
            n_b   = {r_b[WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_b   <= n_b;
    end

    assign o_acc = r_acc;
endmodule

// ----- rtl/modular_exponentiation_64.sv -----
// Top level: right-to-left square-and-multiply over two multiplier cells.
// Depends on mexp_pkg, mexp_if and mexp_cell.
//
//  channel  dir  modport  payload
//  i_in     in   sink     base_value, exponent, modulus
//  o_out    out  source   power_result, zero_modulus_error
//
// One item at a time. Each pass is a load state (S_LOAD), one step per
// multiplier bit (S_RUN) and an update state (S_NEXT). Base reduction takes
// one pass, then one pass per exponent bit up to the highest set bit; the
// result then goes through S_FIN to the output register. A zero modulus
// goes straight from S_IDLE to S_FIN.
// Square and multiply run side by side in the two cells, 64 steps each.
// Reset is synchronous, active low. A stalled result holds in the output
// register while the next item is taken.
module modular_exponentiation_64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mexp_in_if.sink     i_in,
    mexp_out_if.source  o_out
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_RUN, S_NEXT, S_FIN} t_state;

    t_state    r_state;
    t_cnt      r_cnt;
    logic      r_red;
    t_word     r_e, r_m, r_base, r_sq, r_res;
    logic      r_err;
    logic      r_out_valid;
    t_word     r_out_res;
    logic      r_out_err;
    t_cell_ctl w_ctl;
    t_word     w_a0, w_b0, w_acc0, w_acc1;

    // Drive the cells from the sequencer state
    always_comb begin
        w_ctl.start = (r_state == S_LOAD);
        w_ctl.step  = (r_state == S_RUN);
        w_a0 = r_red ? t_word'(1) : r_sq;
        w_b0 = r_red ? r_base : r_sq;
    end

    // Square cell (also reduces the base)
    mexp_cell u_sq (
        .i_clk(i_clk), .i_ctl(w_ctl), .i_a(w_a0), .i_b(w_b0), .i_m(r_m), .o_acc(w_acc0)
    );

    // Multiply cell
    mexp_cell u_mul (
        .i_clk(i_clk), .i_ctl(w_ctl), .i_a(r_sq), .i_b(r_res), .i_m(r_m), .o_acc(w_acc1)
    );

    assign i_in.ready               = (r_state == S_IDLE);
    assign o_out.valid              = r_out_valid;
    assign o_out.power_result       = r_out_res;
    assign o_out.zero_modulus_error = r_out_err;

    // Sequence reduction and exponent bits, hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_red       <= 1'b0;
        end else begin
            // Drop the result beat once taken, unless a new one loads now
            if (o_out.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_e    <= i_in.exponent;
                        r_m    <= i_in.modulus;
                        r_base <= i_in.base_value;
                        if (i_in.modulus == '0) begin
                            r_res   <= '0;
                            r_err   <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_err   <= 1'b0;
                            r_red   <= 1'b1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_sq <= w_acc0;
                    if (r_red) begin
                        r_red <= 1'b0;
                        r_res <= (r_e == '0 || r_m != t_word'(1)) ? t_word'(1) : '0;
                        r_state <= (r_e == '0) ? S_FIN : S_LOAD;
                    end else begin
                        if (r_e[0]) begin
                            r_res <= w_acc1;
                        end
                        r_e     <= r_e >> 1;
                        r_state <= ((r_e >> 1) == '0) ? S_FIN : S_LOAD;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_res   <= r_res;
                        r_out_err   <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/mexp_checker.sv -----
// Port-level checker for the modular exponentiation block, with its bind.
// Depends on assert_macros.svh and mexp_pkg.
`include "assert_macros.svh"

module mexp_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  mexp_pkg::t_word i_out_res,
    input  logic            i_out_err
);
    import mexp_pkg::*;

    // A stalled result beat stays up
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid)
    // A stalled result beat keeps its payload
    `CHK_ASSERT(a_out_stable, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> ($stable(i_out_res) && $stable(i_out_err)))
    // An error result carries zero
    `CHK_ASSERT(a_err_zero, i_clk, i_rst_n, (i_out_valid && i_out_err) |-> (i_out_res == '0))
    // One item in work: no input beat right after another
    `CHK_ASSERT(a_one_item, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready)
endmodule

bind modular_exponentiation_64 mexp_checker u_mexp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_res   (o_out.power_result),
    .i_out_err   (o_out.zero_modulus_error)
);

// ----- dv/modular_exponentiation_64_tb.sv -----
// Testbench for modular_exponentiation_64: random and directed base, exponent, modulus beats.
// Depends on mexp_pkg, mexp_if and the block; checks results against an in-bench predictor.
module modular_exponentiation_64_tb;
    import mexp_pkg::*;

    typedef struct {
        t_word base_value;
        t_word exponent;
        t_word modulus;
    } t_job;

    typedef struct {
        t_word power_result;
        logic  zero_modulus_error;
    } t_power;

    logic i_clk;
    logic i_rst_n;
    mexp_in_if  in_ch ();
    mexp_out_if out_ch ();

    modular_exponentiation_64 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_job   job_queue[$];
    t_power power_queue[$];
    int     error_count;
    int     cycle_count;
    bit     beat_sent;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = ~i_clk;
    end

    // Exact (a * b) mod m through a full 128-bit product
    function automatic t_word mul_reduce(t_word a, t_word b, t_word m);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return t_word'(prod % {64'd0, m});
    endfunction

    // Right-to-left square-and-multiply, zero modulus flagged
    function automatic t_power predict_power(t_job job);
        t_power p;
        t_word  acc;
        t_word  sq;
        t_word  e;
        if (job.modulus == '0) begin
            p.power_result = '0;
            p.zero_modulus_error = 1'b1;
            return p;
        end
        acc = 64'd1;
        sq = job.base_value % job.modulus;
        e = job.exponent;
        while (e != '0) begin
            if (e[0]) begin
                acc = mul_reduce(sq, acc % job.modulus, job.modulus);
            end
            sq = mul_reduce(sq, sq, job.modulus);
            e = e >> 1;
        end
        p.power_result = acc;
        p.zero_modulus_error = 1'b0;
        return p;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic add_job(t_word b, t_word e, t_word m);
        t_job j;
        j.base_value = b;
        j.exponent = e;
        j.modulus = m;
        job_queue.insert(job_queue.size(), j);
    endtask

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    // Random word of random bit length, so most items stay short
    function automatic t_word rand_short_word();
        t_word w;
        int    len;
        w = rand_word();
        len = $urandom_range(64, 1);
        return (len == 64) ? w : (w & ((64'd1 << len) - 64'd1));
    endfunction

    // Idle with a chance of about 17 percent, except in a quiet window
    function automatic bit take_gap();
        if ((cycle_count / 20000) % 4 == 1) begin
            return 1'b0;
        end
        return $urandom_range(99, 0) < 17;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Record accepted input beats and check result beats
    always @(posedge i_clk) begin
        t_job   j;
        t_power got;
        t_power want;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            j.base_value = in_ch.base_value;
            j.exponent = in_ch.exponent;
            j.modulus = in_ch.modulus;
            power_queue.insert(power_queue.size(), predict_power(j));
            beat_sent = 1'b1;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.power_result = out_ch.power_result;
            got.zero_modulus_error = out_ch.zero_modulus_error;
            if (power_queue.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = power_queue.pop_front();
                if (got.power_result !== want.power_result) begin
                    report_mismatch($sformatf("power_result %h, expected %h",
                                              got.power_result, want.power_result));
                end
                if (got.zero_modulus_error !== want.zero_modulus_error) begin
                    report_mismatch($sformatf("zero_modulus_error %b, expected %b",
                                              got.zero_modulus_error,
                                              want.zero_modulus_error));
                end
            end
        end
    end

    // Drive input beats and result stalls on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !take_gap();
            if (!in_ch.valid || beat_sent) begin
                beat_sent = 1'b0;
                if (job_queue.size() == 0 || take_gap()) begin
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid <= 1'b1;
                    in_ch.base_value <= job_queue[0].base_value;
                    in_ch.exponent <= job_queue[0].exponent;
                    in_ch.modulus <= job_queue[0].modulus;
                    job_queue.pop_front();
                end
            end
        end
    end

    // Fill the pending items, run, then judge
    initial begin
        error_count = 0;
        cycle_count = 0;
        beat_sent = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.base_value = '0;
        in_ch.exponent = '0;
        in_ch.modulus = '0;
        out_ch.ready = 1'b0;

        // zero modulus, whatever the exponent
        add_job(64'd5, 64'd0, 64'd0);
        add_job('1, '1, 64'd0);
        add_job(64'd7, 64'd3, 64'd0);
        // zero exponent returns one, even for modulus one
        add_job(64'd9, 64'd0, 64'd1);
        add_job('1, 64'd0, '1);
        // modulus one with nonzero exponent
        add_job(64'd12345, 64'd17, 64'd1);
        add_job('1, '1, 64'd1);
        // field extremes
        add_job('1, '1, '1);
        add_job(64'd0, 64'd1, '1);
        add_job(64'd0, '1, 64'd97);
        add_job(64'd1, '1, '1);
        add_job('1, 64'd1, '1);
        add_job('1, 64'd2, 64'hFFFF_FFFF_FFFF_FFC5);
        add_job(64'hFFFF_FFFF_FFFF_FFFE, 64'd2, '1);
        add_job(64'd1000, 64'd5, 64'd7);
        add_job(64'd2, 64'd63, 64'h8000_0000_0000_0000);
        add_job(64'h8000_0000_0000_0000, '1, 64'hFFFF_FFFF_FFFF_FFC5);
        add_job(64'd3, 64'h8000_0000_0000_0000, 64'd1_000_000_007);
        add_job(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAB);
        add_job(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);

        // random items: mostly short exponents, some full-width
        for (int n = 0; n < 80; n++) begin
            t_word b;
            t_word e;
            t_word m;
            b = rand_word();
            e = ($urandom_range(9, 0) == 0) ? rand_word() : rand_short_word();
            case ($urandom_range(9, 0))
                0: m = 64'd0;
                1: m = 64'd1;
                2, 3: m = rand_short_word();
                default: m = rand_word();
            endcase
            if ($urandom_range(9, 0) == 0) begin
                e = '0;
            end
            add_job(b, e, m);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (job_queue.size() != 0 || power_queue.size() != 0 || in_ch.valid) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
